// ----- hdl/assert_macros.svh -----
// Assertion helpers included by the terminal writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define AST_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/tmtw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtw_pkg
// Geometry, codes and the sequencer state type of the text terminal writer.
// ----------------------------------------------------------------------------
package tmtw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);

	localparam logic [15:0] BLANK_CELL   = 16'h0720;
	localparam logic [7:0]  NEWLINE_CODE = 8'd10;
	localparam logic [7:0]  COLOR_RESET  = 8'd7;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCROLL_RD,
		ST_SCROLL_WR,
		ST_BLANK,
		ST_RESP
	} state_t;

endpackage

// ----- hdl/text_mode_terminal_writer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_unit
// Character-cell terminal: cursor, put/newline/scroll, cell reads.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | tuser: operation; tdata: char_code, read_address
//  m_axis    | out       | tdata: cell_value, cursor_row, cursor_column, scrolled
//  text_color| in        | write enable + 8-bit attribute byte
//
// Steps: a put is accepted, then its result is offered; a read is accepted,
// the RAM is read, then the result is offered; a put that scrolls copies each
// row up through the single RAM port pair (one read, one write per cell),
// blanks the last row, then offers the result. After reset a clearing pass
// writes blanks over the whole store before s_tready rises. One transaction
// is worked at a time; s_tready stays low until the result has been taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_mode_terminal_writer_unit
	import tmtw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,          // [7:0] char_code, [18:8] read_address
	input  logic        s_tuser,          // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,          // [15:0] cell_value, [20:16] cursor_row,
	                                      // [27:21] cursor_column, [28] scrolled
	input  logic        text_color_wen,
	input  logic [7:0]  text_color_wdata
);

	// Sequencer and cursor state
	state_t             state_q, state_d;
	logic [ADDR_W-1:0]  cnt_q;            // sweep index for clear and scroll
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [ADDR_W-1:0]  base_q;           // row_q * COLUMNS, kept incrementally
	logic [7:0]         color_q;

	// Result registers
	logic [15:0]        cell_q;
	logic               scrolled_q;
	logic               in_range_q;

	// Screen store
	logic [15:0]        mem [CELL_COUNT];
	logic [15:0]        rdata_q;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [15:0]        mem_wdata;
	logic [ADDR_W-1:0]  mem_raddr;

	// Input decode
	logic               accept;
	logic [7:0]         in_char;
	logic [10:0]        in_addr;
	logic               is_newline;
	logic               wrap;
	logic               at_bottom;
	logic               do_scroll;
	logic               in_range;
	logic [ADDR_W-1:0]  cursor_addr;
	logic [31:0]        row_ext;
	logic [31:0]        col_ext;

	assign accept      = s_tvalid && s_tready;
	assign in_char     = s_tdata[7:0];
	assign in_addr     = s_tdata[18:8];
	assign is_newline  = (in_char == NEWLINE_CODE);
	// a newline or a character in the last column both move to the next row
	assign wrap        = is_newline || (col_q == COL_W'(COLUMNS - 1));
	assign at_bottom   = (row_q == ROW_W'(ROWS - 1));
	assign do_scroll   = (s_tuser == OP_PUT) && wrap && at_bottom;
	assign in_range    = (32'(in_addr) < 32'(CELL_COUNT));
	assign cursor_addr = ADDR_W'(base_q + ADDR_W'(col_q));

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (cnt_q == ADDR_W'(CELL_COUNT - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == OP_READ)
						state_d = ST_READ;
					else if (do_scroll)
						state_d = ST_SCROLL_RD;
					else
						state_d = ST_RESP;
				end
			end
			ST_READ:      state_d = ST_RESP;
			ST_SCROLL_RD: state_d = ST_SCROLL_WR;
			ST_SCROLL_WR: begin
				if (cnt_q == ADDR_W'(CELL_COUNT - COLUMNS - 1))
					state_d = ST_BLANK;
				else
					state_d = ST_SCROLL_RD;
			end
			ST_BLANK: begin
				if (cnt_q == ADDR_W'(CELL_COUNT - 1))
					state_d = ST_RESP;
			end
			ST_RESP: begin
				if (m_tready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Outputs and RAM port control
	// ------------------------------------------------------------------
	always_comb begin
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = BLANK_CELL;
		mem_raddr = ADDR_W'(in_addr);
		unique case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_IDLE: begin
				s_tready = 1'b1;
				// character write at the cursor happens in the accept cycle
				if (accept && (s_tuser == OP_PUT) && !is_newline) begin
					mem_we    = 1'b1;
					mem_waddr = cursor_addr;
					mem_wdata = {color_q, in_char};
				end
			end
			ST_READ: ;
			ST_SCROLL_RD: mem_raddr = ADDR_W'(cnt_q + ADDR_W'(COLUMNS));
			ST_SCROLL_WR: begin
				mem_we    = 1'b1;
				mem_wdata = rdata_q;
			end
			ST_BLANK: mem_we = 1'b1;
			ST_RESP:  m_tvalid = 1'b1;
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Screen store: one write port, one registered read port
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	// ------------------------------------------------------------------
	// Control and cursor registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			base_q  <= '0;
			color_q <= COLOR_RESET;
		end else begin
			state_q <= state_d;
			if (text_color_wen)
				color_q <= text_color_wdata;
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == ADDR_W'(CELL_COUNT - 1))
						cnt_q <= '0;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_IDLE: begin
					if (accept && (s_tuser == OP_PUT)) begin
						cnt_q <= '0;
						if (wrap) begin
							col_q <= '0;
							// on the last row the cursor stays; the screen scrolls
							if (!at_bottom) begin
								row_q  <= row_q + 1'b1;
								base_q <= ADDR_W'(base_q + ADDR_W'(COLUMNS));
							end
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				ST_SCROLL_WR, ST_BLANK: cnt_q <= cnt_q + 1'b1;
				ST_READ, ST_SCROLL_RD, ST_RESP: ;
				default: ;
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cell_q     <= '0;
			in_range_q <= in_range;
			scrolled_q <= do_scroll;
		end else if (state_q == ST_READ) begin
			cell_q <= in_range_q ? rdata_q : 16'h0000;
		end
	end

	assign row_ext = 32'(row_q);
	assign col_ext = 32'(col_q);
	assign m_tdata = {3'b000, scrolled_q, col_ext[6:0], row_ext[4:0], cell_q};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`AST_NEXT(a_col_step, clk, arst_n,
		accept && (s_tuser == OP_PUT) && !wrap,
		col_q == COL_W'($past(col_q) + 1'b1), "cursor column did not advance")
	`AST_IMPL(a_scroll_row, clk, arst_n,
		(state_q == ST_SCROLL_RD) || (state_q == ST_SCROLL_WR) || (state_q == ST_BLANK),
		at_bottom, "scroll pass with cursor off the last row")
	`AST_IMPL(a_scrolled_flag, clk, arst_n, m_tvalid && scrolled_q,
		at_bottom && (col_q == '0), "scrolled result with cursor not at last row start")
	`AST_IMPL(a_one_at_a_time, clk, arst_n, m_tvalid, !s_tready,
		"input taken while a result is pending")

endmodule
